@@ sv/tqsw_pkg.sv @@
// Shared types and constants for the task queue with timed wakeup.
// Holds operation and status codes plus the controller/datapath command and status words.
// No dependencies.
package tqsw_pkg;

	localparam logic [1:0] ACT_PUT    = 2'd0;
	localparam logic [1:0] ACT_POP    = 2'd1;
	localparam logic [1:0] ACT_REMOVE = 2'd2;
	localparam logic [1:0] ACT_TICK   = 2'd3;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_MISS = 2'd1;
	localparam logic [1:0] STAT_FULL = 2'd2;

	typedef struct packed {
		logic accept;
		logic walk_en;
		logic load_single;
		logic rel_rd;
		logic load_rel;
	} cmd_t;

	typedef struct packed {
		logic in_put;
		logic walk_done;
		logic has_rel;
		logic rel_last;
		logic out_free;
	} sts_t;

endpackage

@@ sv/tqsw_ctrl.sv @@
// Controller state machine for the task queue.
// Sequences accept, the compaction walk and result delivery; depends on tqsw_pkg.
module tqsw_ctrl
	import tqsw_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_WALK   = 5'b00010,
		S_SINGLE = 5'b00100,
		S_REL_RD = 5'b01000,
		S_REL_LD = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.accept = 1'b1;
					state_d = sts.in_put ? S_SINGLE : S_WALK;
				end
			end
			S_WALK: begin
				cmd.walk_en = 1'b1;
				if (sts.walk_done) begin
					state_d = sts.has_rel ? S_REL_RD : S_SINGLE;
				end
			end
			S_SINGLE: begin
				if (sts.out_free) begin
					cmd.load_single = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_REL_RD: begin
				cmd.rel_rd = 1'b1;
				state_d = S_REL_LD;
			end
			S_REL_LD: begin
				if (sts.out_free) begin
					cmd.load_rel = 1'b1;
					state_d = sts.rel_last ? S_IDLE : S_REL_RD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_stall = (state_q != S_IDLE);

endmodule

@@ sv/tqsw_dp.sv @@
// Datapath for the task queue: slot memories, released-id buffer, counters and output register.
// Driven by commands from tqsw_ctrl; depends on tqsw_pkg.
module tqsw_dp
	import tqsw_pkg::*;
#(
	parameter int DEPTH   = 16,
	parameter int ID_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [1:0]  action,
	input  logic [7:0]  task_id,
	input  logic [15:0] sleep_ticks,
	input  cmd_t        cmd,
	output sts_t        sts,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [7:0]  out_id,
	output logic        out_valid,
	output logic [1:0]  status,
	output logic [4:0]  entry_total,
	output logic        is_empty,
	output logic [7:0]  head_id,
	output logic        last
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [ID_BITS-1:0] slot_ids [DEPTH];
	logic [15:0]        slot_ticks [DEPTH];
	logic [ID_BITS-1:0] rel_ids [DEPTH];

	logic [1:0]         op_q;
	logic [ID_BITS-1:0] id_q;
	logic               full_q;
	logic               found_q;
	logic [ID_BITS-1:0] pop_id_q;
	logic [CW-1:0]      fill_q;
	logic [ID_BITS-1:0] head_q;
	logic [CW-1:0]      rd_q;
	logic [CW-1:0]      wr_q;
	logic [CW-1:0]      rel_cnt_q;
	logic [CW-1:0]      emit_q;

	logic               pend_s1;
	logic               first_s1;
	logic [ID_BITS-1:0] id_s1;
	logic [15:0]        tk_s1;
	logic [ID_BITS-1:0] rel_s1;

	logic               res_valid_q;
	logic [7:0]         out_id_q;
	logic               out_vld_q;
	logic [1:0]         status_q;
	logic [4:0]         total_q;
	logic               empty_q;
	logic [7:0]         head_out_q;
	logic               last_q;

	logic [ID_BITS-1:0] id_in;
	logic               put_ok;
	logic               issue;
	logic               drop;
	logic               keep;
	logic               mem_we;
	logic [AW-1:0]      mem_addr;
	logic [ID_BITS-1:0] mem_id;
	logic [15:0]        mem_tk;
	logic               rel_we;

	assign id_in  = ID_BITS'(task_id);
	assign put_ok = (fill_q < CW'(DEPTH));
	assign issue  = cmd.walk_en && (rd_q < fill_q);

	always_comb begin
		case (op_q)
			ACT_POP:    drop = first_s1;
			ACT_REMOVE: drop = !found_q && (id_s1 == id_q);
			ACT_TICK:   drop = (tk_s1 <= 16'd1);
			default:    drop = 1'b0;
		endcase
	end

	assign keep   = cmd.walk_en && pend_s1 && !drop;
	assign rel_we = cmd.walk_en && pend_s1 && drop && (op_q == ACT_TICK);

	always_comb begin
		mem_we   = 1'b0;
		mem_addr = wr_q[AW-1:0];
		mem_id   = id_s1;
		mem_tk   = (op_q == ACT_TICK) ? (tk_s1 - 16'd1) : tk_s1;
		if (cmd.accept && sts.in_put) begin
			mem_we   = put_ok;
			mem_addr = fill_q[AW-1:0];
			mem_id   = id_in;
			mem_tk   = sleep_ticks;
		end else if (keep) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			slot_ids[mem_addr]   <= mem_id;
			slot_ticks[mem_addr] <= mem_tk;
		end
		if (issue) begin
			id_s1 <= slot_ids[rd_q[AW-1:0]];
			tk_s1 <= slot_ticks[rd_q[AW-1:0]];
		end
		if (rel_we) begin
			rel_ids[rel_cnt_q[AW-1:0]] <= id_s1;
		end
		if (cmd.rel_rd) begin
			rel_s1 <= rel_ids[emit_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q      <= ACT_PUT;
			id_q      <= '0;
			full_q    <= 1'b0;
			found_q   <= 1'b0;
			pop_id_q  <= '0;
			fill_q    <= '0;
			head_q    <= '0;
			rd_q      <= '0;
			wr_q      <= '0;
			rel_cnt_q <= '0;
			emit_q    <= '0;
			pend_s1   <= 1'b0;
			first_s1  <= 1'b0;
		end else begin
			if (cmd.accept) begin
				op_q      <= action;
				id_q      <= id_in;
				found_q   <= 1'b0;
				rd_q      <= '0;
				wr_q      <= '0;
				rel_cnt_q <= '0;
				emit_q    <= '0;
				pend_s1   <= 1'b0;
				if (sts.in_put) begin
					full_q <= !put_ok;
					if (put_ok) begin
						fill_q <= fill_q + CW'(1);
						if (fill_q == '0) begin
							head_q <= id_in;
						end
					end
				end else begin
					head_q <= '0;
				end
			end
			if (cmd.walk_en) begin
				pend_s1  <= issue;
				first_s1 <= (rd_q == '0);
				if (issue) begin
					rd_q <= rd_q + CW'(1);
				end
				if (pend_s1 && drop) begin
					found_q  <= 1'b1;
					pop_id_q <= id_s1;
				end
				if (rel_we) begin
					rel_cnt_q <= rel_cnt_q + CW'(1);
				end
				if (keep) begin
					wr_q <= wr_q + CW'(1);
					if (wr_q == '0) begin
						head_q <= id_s1;
					end
				end
				if (sts.walk_done) begin
					fill_q <= wr_q;
				end
			end
			if (cmd.load_rel) begin
				emit_q <= emit_q + CW'(1);
			end
		end
	end

	assign sts.in_put    = (action == ACT_PUT);
	assign sts.walk_done = (rd_q == fill_q) && !pend_s1;
	assign sts.has_rel   = (rel_cnt_q != '0);
	assign sts.rel_last  = ((emit_q + CW'(1)) == rel_cnt_q);
	assign sts.out_free  = !res_valid_q || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.load_single || cmd.load_rel) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_single || cmd.load_rel) begin
			total_q    <= 5'(fill_q);
			empty_q    <= (fill_q == '0);
			head_out_q <= 8'(head_q);
		end
		if (cmd.load_rel) begin
			out_id_q  <= 8'(rel_s1);
			out_vld_q <= 1'b1;
			status_q  <= STAT_OK;
			last_q    <= sts.rel_last;
		end else if (cmd.load_single) begin
			last_q <= 1'b1;
			case (op_q)
				ACT_PUT: begin
					out_id_q  <= '0;
					out_vld_q <= 1'b0;
					status_q  <= full_q ? STAT_FULL : STAT_OK;
				end
				ACT_POP: begin
					out_id_q  <= found_q ? 8'(pop_id_q) : 8'd0;
					out_vld_q <= found_q;
					status_q  <= found_q ? STAT_OK : STAT_MISS;
				end
				ACT_REMOVE: begin
					out_id_q  <= '0;
					out_vld_q <= 1'b0;
					status_q  <= found_q ? STAT_OK : STAT_MISS;
				end
				default: begin
					out_id_q  <= '0;
					out_vld_q <= 1'b0;
					status_q  <= STAT_OK;
				end
			endcase
		end
	end

	assign res_valid   = res_valid_q;
	assign out_id      = out_id_q;
	assign out_valid   = out_vld_q;
	assign status      = status_q;
	assign entry_total = total_q;
	assign is_empty    = empty_q;
	assign head_id     = head_out_q;
	assign last        = last_q;

endmodule

@@ sv/task_queue_with_sleep_wakeup_core.sv @@
// Task queue with timed wakeup: put, pop, remove by id and tick over up to DEPTH entries.
// Put goes straight to its result load; pop, remove and tick walk every held entry through
// one memory read port, and a tick then reads each released word from the release buffer
// before loading it into the result register. One item is in work at a time.
// The result register lets the next item be accepted while the last word waits.
// Reset clears the fill count, head and handshake state; slot memories are not cleared.
module task_queue_with_sleep_wakeup_core
	import tqsw_pkg::*;
#(
	parameter int DEPTH   = 16,
	parameter int ID_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  action,
	input  logic [7:0]  task_id,
	input  logic [15:0] sleep_ticks,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [7:0]  out_id,
	output logic        out_valid,
	output logic [1:0]  status,
	output logic [4:0]  entry_total,
	output logic        is_empty,
	output logic [7:0]  head_id,
	output logic        last
);

	cmd_t cmd;
	sts_t sts;

	tqsw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	tqsw_dp #(
		.DEPTH   (DEPTH),
		.ID_BITS (ID_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.action      (action),
		.task_id     (task_id),
		.sleep_ticks (sleep_ticks),
		.cmd         (cmd),
		.sts         (sts),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.out_id      (out_id),
		.out_valid   (out_valid),
		.status      (status),
		.entry_total (entry_total),
		.is_empty    (is_empty),
		.head_id     (head_id),
		.last        (last)
	);

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_single || cmd.load_rel) |-> sts.out_free)
		else $error("Result loaded while the output word was still held.");

	a_rel_present: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_rel |-> sts.has_rel)
		else $error("Released word emitted with an empty release buffer.");

	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.accept, cmd.walk_en, cmd.load_single, cmd.rel_rd, cmd.load_rel}))
		else $error("Controller issued more than one command in a cycle.");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> req_stall)
		else $error("Input not stalled while an item is in work.");

endmodule
